// File: design/easter_holiday_dates_macros.svh
// Assertion macros used by the checker file of the Easter dates block.
`ifndef EASTER_HOLIDAY_DATES_MACROS_SVH
`define EASTER_HOLIDAY_DATES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EHD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: design/ehd_pkg.sv
// Types, constants and date helpers for the Easter dates block.
package ehd_pkg;

	localparam int YEAR_W = 14;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 3;
	localparam int OFF_W  = 7;

	// Reciprocal multipliers; each shift is noted beside its constant.
	localparam logic [12:0] RECIP100 = 13'd5243;   // >> 19
	localparam logic [14:0] RECIP19  = 15'd27595;  // >> 19
	localparam logic [5:0]  RECIP25  = 6'd41;      // >> 10
	localparam logic [7:0]  RECIP3   = 8'd171;     // >> 9
	localparam logic [9:0]  RECIP30  = 10'd547;    // >> 14
	localparam logic [7:0]  RECIP7   = 8'd147;     // >> 10

	localparam logic [MON_W-1:0] MON_FEB = 3'd2;
	localparam logic [MON_W-1:0] MON_MAR = 3'd3;
	localparam logic [MON_W-1:0] MON_APR = 3'd4;
	localparam logic [MON_W-1:0] MON_MAY = 3'd5;
	localparam logic [MON_W-1:0] MON_JUN = 3'd6;

	typedef struct packed {
		logic [MON_W-1:0] month;
		logic [DAY_W-1:0] day;
	} date_t;

	// Zero-based day offset from March 1 to month and day.
	function automatic date_t from_march(input logic [OFF_W-1:0] off);
		date_t r;
		priority if (off < 7'd31) begin
			r.month = MON_MAR;
			r.day   = DAY_W'(off + 7'd1);
		end else if (off < 7'd61) begin
			r.month = MON_APR;
			r.day   = DAY_W'(off - 7'd30);
		end else if (off < 7'd92) begin
			r.month = MON_MAY;
			r.day   = DAY_W'(off - 7'd60);
		end else begin
			r.month = MON_JUN;
			r.day   = DAY_W'(off - 7'd91);
		end
		return r;
	endfunction

	// Carnival lands in February when Easter is less than 49 days past March 1.
	function automatic date_t carnival_date(input logic [OFF_W-1:0] off, input logic leap);
		date_t r;
		logic [OFF_W-1:0] feb;
		feb = leap ? 7'd29 : 7'd28;
		if (off >= 7'd49) begin
			r = from_march(off - 7'd49);
		end else begin
			r.month = MON_FEB;
			r.day   = DAY_W'(feb + off - 7'd48);
		end
		return r;
	endfunction

endpackage

// File: design/ehd_if.sv
// Valid/ready channel interfaces for years in and feast dates out.
interface ehd_year_if import ehd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [YEAR_W-1:0] year;

	modport source (output valid, output year, input ready);
	modport sink   (input valid, input year, output ready);
endinterface

interface ehd_dates_if import ehd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       carnival_month;
	logic [DAY_W-1:0] carnival_day;
	logic [MON_W-1:0] good_friday_month;
	logic [DAY_W-1:0] good_friday_day;
	logic [MON_W-1:0] easter_month_out;
	logic [DAY_W-1:0] easter_day_out;
	logic [MON_W-1:0] ascension_month;
	logic [DAY_W-1:0] ascension_day;
	logic [MON_W-1:0] whitsun_month;
	logic [DAY_W-1:0] whitsun_day;

	modport source (
		output valid, input ready,
		output carnival_month, output carnival_day,
		output good_friday_month, output good_friday_day,
		output easter_month_out, output easter_day_out,
		output ascension_month, output ascension_day,
		output whitsun_month, output whitsun_day
	);
	modport sink (
		input valid, output ready,
		input carnival_month, input carnival_day,
		input good_friday_month, input good_friday_day,
		input easter_month_out, input easter_day_out,
		input ascension_month, input ascension_day,
		input whitsun_month, input whitsun_day
	);
endinterface

// File: design/easter_holiday_dates.sv
// An accepted year moves through the stage registers to its result item on the output register.
// Throughput: one year per cycle while the output is not stalled; eight register stages, each advancing when it is
// empty or its successor advances, so bubbles close up behind a stalled output.
// Reset: arst_n clears the stage valid bits at once; the data registers are not reset.
// The computus runs as reciprocal multiplies by constants, at most two per stage.
module easter_holiday_dates import ehd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ehd_year_if.sink    year_ch,
	ehd_dates_if.source dates_ch
);

	logic [8:1] vld_q;
	logic [8:1] en;

	// Stage 1: quotients by 100 and 19.
	logic [26:0] prod100;
	logic [28:0] prod19;
	logic [YEAR_W-1:0] y_s1;
	logic [7:0] b_s1;
	logic [9:0] q19_s1;

	// Stage 2: remainders and f.
	logic [13:0] t19, t100;
	logic [14:0] pf;
	logic [4:0] a_s2;
	logic [7:0] b_s2;
	logic [6:0] c_s2;
	logic [2:0] f_s2;
	logic [1:0] ylo_s2;

	// Stage 3: g and the century and year splits.
	logic [8:0] gnum;
	logic [16:0] pg;
	logic [4:0] a_s3;
	logic [7:0] b_s3;
	logic [5:0] d_s3, g_s3;
	logic [1:0] e_s3, k_s3;
	logic [4:0] i_s3;
	logic leap_s3;

	// Stage 4: numerator of h.
	logic [9:0] v_s4;
	logic [4:0] a_s4;
	logic [1:0] e_s4, k_s4;
	logic [4:0] i_s4;
	logic leap_s4;

	// Stage 5: h.
	logic [19:0] p30;
	logic [9:0] t30;
	logic [4:0] h_s5, a_s5;
	logic [1:0] e_s5, k_s5;
	logic [4:0] i_s5;
	logic leap_s5;

	// Stage 6: l.
	logic [6:0] w;
	logic [14:0] p7;
	logic [6:0] t7;
	logic [2:0] l_s6;
	logic [4:0] h_s6, a_s6;
	logic leap_s6;

	// Stage 7: Easter offset from March 1.
	logic [8:0] mnum;
	logic [OFF_W-1:0] off_s7;
	logic leap_s7;

	// Stage 8: output register.
	date_t carn_s8, gfri_s8, east_s8, asc_s8, whit_s8;

	always_comb begin
		en[8] = !vld_q[8] || dates_ch.ready;
		for (int k = 7; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign year_ch.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= year_ch.valid;
			end
			for (int k = 2; k <= 8; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign prod100 = 27'(year_ch.year) * 27'(RECIP100);
	assign prod19  = 29'(year_ch.year) * 29'(RECIP19);

	assign t19  = y_s1 - 14'(q19_s1) * 14'd19;
	assign t100 = y_s1 - 14'(b_s1) * 14'd100;
	assign pf   = (15'(b_s1) + 15'd8) * 15'(RECIP25);

	assign gnum = 9'(b_s2) - 9'(f_s2) + 9'd1;
	assign pg   = 17'(gnum) * 17'(RECIP3);

	assign p30 = 20'(v_s4) * 20'(RECIP30);
	assign t30 = v_s4 - 10'(p30[18:14]) * 10'd30;

	assign w  = 7'd32 + 7'({e_s5, 1'b0}) + 7'({i_s5, 1'b0}) - 7'(h_s5) - 7'(k_s5);
	assign p7 = 15'(w) * 15'(RECIP7);
	assign t7 = w - 7'(p7[14:10]) * 7'd7;

	assign mnum = 9'(a_s6) + 9'(h_s6) * 9'd11 + 9'(l_s6) * 9'd22;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			y_s1   <= year_ch.year;
			b_s1   <= prod100[26:19];
			q19_s1 <= prod19[28:19];
		end
		if (en[2]) begin
			a_s2   <= t19[4:0];
			b_s2   <= b_s1;
			c_s2   <= t100[6:0];
			f_s2   <= pf[12:10];
			ylo_s2 <= y_s1[1:0];
		end
		if (en[3]) begin
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			d_s3 <= b_s2[7:2];
			e_s3 <= b_s2[1:0];
			g_s3 <= pg[14:9];
			i_s3 <= c_s2[6:2];
			k_s3 <= c_s2[1:0];
			// Century years are leap only when the century count is a multiple of four.
			leap_s3 <= (ylo_s2 == 2'd0) && ((c_s2 != 7'd0) || (b_s2[1:0] == 2'd0));
		end
		if (en[4]) begin
			v_s4    <= 10'(a_s3) * 10'd19 + 10'(b_s3) - 10'(d_s3) - 10'(g_s3) + 10'd15;
			a_s4    <= a_s3;
			e_s4    <= e_s3;
			i_s4    <= i_s3;
			k_s4    <= k_s3;
			leap_s4 <= leap_s3;
		end
		if (en[5]) begin
			h_s5    <= t30[4:0];
			a_s5    <= a_s4;
			e_s5    <= e_s4;
			i_s5    <= i_s4;
			k_s5    <= k_s4;
			leap_s5 <= leap_s4;
		end
		if (en[6]) begin
			l_s6    <= t7[2:0];
			h_s6    <= h_s5;
			a_s6    <= a_s5;
			leap_s6 <= leap_s5;
		end
		if (en[7]) begin
			// The numerator never reaches twice 451, so m is a single compare.
			off_s7  <= 7'(h_s6) + 7'(l_s6) + 7'd21 - ((mnum >= 9'd451) ? 7'd7 : 7'd0);
			leap_s7 <= leap_s6;
		end
		if (en[8]) begin
			carn_s8 <= carnival_date(off_s7, leap_s7);
			gfri_s8 <= from_march(off_s7 - 7'd2);
			east_s8 <= from_march(off_s7);
			asc_s8  <= from_march(off_s7 + 7'd39);
			whit_s8 <= from_march(off_s7 + 7'd49);
		end
	end

	assign dates_ch.valid             = vld_q[8];
	assign dates_ch.carnival_month    = carn_s8.month[1:0];
	assign dates_ch.carnival_day      = carn_s8.day;
	assign dates_ch.good_friday_month = gfri_s8.month;
	assign dates_ch.good_friday_day   = gfri_s8.day;
	assign dates_ch.easter_month_out  = east_s8.month;
	assign dates_ch.easter_day_out    = east_s8.day;
	assign dates_ch.ascension_month   = asc_s8.month;
	assign dates_ch.ascension_day     = asc_s8.day;
	assign dates_ch.whitsun_month     = whit_s8.month;
	assign dates_ch.whitsun_day       = whit_s8.day;

endmodule

// File: design/ehd_checker.sv
// Port-level checks on the Easter dates block and their binding to it.
`include "easter_holiday_dates_macros.svh"

module ehd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] good_friday_month,
	input logic [4:0] good_friday_day,
	input logic [2:0] sunday_month,
	input logic [4:0] sunday_day,
	input logic [2:0] ascension_month,
	input logic [4:0] ascension_day,
	input logic [2:0] whitsun_month,
	input logic [4:0] whitsun_day
);

	// A waiting result item keeps its Easter month and day and its Whitsun day.
	`EHD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sunday_day) && $stable(sunday_month) && $stable(whitsun_day))

	// Easter Sunday always falls between March 22 and April 25.
	`EHD_ASSERT_IMP(a_easter_window, clk, arst_n, out_valid, (sunday_month == 3'd3 && sunday_day >= 5'd22) || (sunday_month == 3'd4 && sunday_day <= 5'd25))

	// Good Friday is two days before Easter within the same month when room allows.
	`EHD_ASSERT_IMP(a_good_friday, clk, arst_n, out_valid && sunday_day >= 5'd3, good_friday_month == sunday_month && good_friday_day == sunday_day - 5'd2)

	// Whitsuntide follows Ascension by ten days.
	`EHD_ASSERT_IMP(a_whitsun_step, clk, arst_n, out_valid && ascension_day <= 5'd21, whitsun_month == ascension_month && whitsun_day == ascension_day + 5'd10)

endmodule

bind easter_holiday_dates ehd_checker u_ehd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (dates_ch.valid),
	.out_ready         (dates_ch.ready),
	.good_friday_month (dates_ch.good_friday_month),
	.good_friday_day   (dates_ch.good_friday_day),
	.sunday_month      (dates_ch.easter_month_out),
	.sunday_day        (dates_ch.easter_day_out),
	.ascension_month   (dates_ch.ascension_month),
	.ascension_day     (dates_ch.ascension_day),
	.whitsun_month     (dates_ch.whitsun_month),
	.whitsun_day       (dates_ch.whitsun_day)
);
